@@ rtl/rv32i_execute_step_top_assert.svh @@
// ----------------------------------------------------------------------------
// RV32I execute step: assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef RV32I_EXECUTE_STEP_TOP_ASSERT_SVH
`define RV32I_EXECUTE_STEP_TOP_ASSERT_SVH

// same-cycle implication
`define RVX_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RVX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rvx_pkg.sv @@
// ----------------------------------------------------------------------------
// RV32I execute step package
// Opcodes, status and function codes, and the execute result struct.
// ----------------------------------------------------------------------------
package rvx_pkg;

    localparam int MEM_BYTES_DEF = 16384;

    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_FENCE  = 7'b0001111;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;
    localparam logic [6:0] F7_ALT    = 7'b0100000;

    localparam logic [31:0] INS_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INS_EBREAK = 32'h0010_0073;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_ECALL   = 3'd1;
    localparam logic [2:0] STAT_EBREAK  = 3'd2;
    localparam logic [2:0] STAT_FENCE   = 3'd3;
    localparam logic [2:0] STAT_UNKNOWN = 3'd4;
    localparam logic [2:0] STAT_ILLEGAL = 3'd5;

    localparam logic [1:0] FUNC_EXEC    = 2'd0;
    localparam logic [1:0] FUNC_SYSRET  = 2'd1;
    localparam logic [1:0] FUNC_START   = 2'd2;
    localparam logic [1:0] FUNC_PRELOAD = 2'd3;

    localparam logic CFG_ENTRY = 1'b0;
    localparam logic CFG_STACK = 1'b1;

    localparam logic [4:0] REG_SP = 5'd2;
    localparam logic [4:0] REG_A0 = 5'd10;
    localparam logic [4:0] REG_A1 = 5'd11;
    localparam logic [4:0] REG_A2 = 5'd12;
    localparam logic [4:0] REG_A3 = 5'd13;
    localparam logic [4:0] REG_A4 = 5'd14;
    localparam logic [4:0] REG_A7 = 5'd17;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] npc;
        logic        rd_we;
        logic [4:0]  rd;
        logic [31:0] value;
        logic        load;
        logic        store;
        logic [31:0] addr;
        logic [2:0]  f3;
    } exec_res_t;

endpackage

@@ rtl/rvx_regfile.sv @@
// ----------------------------------------------------------------------------
// RV32I register file
// Two synchronous copies, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rvx_regfile
    import rvx_pkg::*;
(
    input  logic        clk,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata,
    input  logic        re,
    input  logic [4:0]  raddr_a,
    input  logic [4:0]  raddr_b,
    output logic [31:0] rdata_a,
    output logic [31:0] rdata_b
);

    logic [31:0] mem_a [32];
    logic [31:0] mem_b [32];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_a[waddr] <= wdata;
            mem_b[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem_a[raddr_a];
            rdata_b <= mem_b[raddr_b];
        end
    end

endmodule

@@ rtl/rvx_dmem.sv @@
// ----------------------------------------------------------------------------
// RV32I data memory
// Four byte-lane banks; lane k holds the bytes whose address ends in k.
// ----------------------------------------------------------------------------
module rvx_dmem
    import rvx_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF,
    localparam int ROWS = MEM_BYTES / 4,
    localparam int RW = $clog2(ROWS)
)
(
    input  logic                  clk,
    input  logic [3:0]            we,
    input  logic [3:0][RW-1:0]    waddr,
    input  logic [3:0][7:0]       wdata,
    input  logic                  re,
    input  logic [3:0][RW-1:0]    raddr,
    output logic [3:0][7:0]       rdata
);

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        logic [7:0] bank [ROWS];
        logic [7:0] rdata_reg;

        always_ff @(posedge clk)
        begin
            if (we[k])
            begin
                bank[waddr[k]] <= wdata[k];
            end
            if (re)
            begin
                rdata_reg <= bank[raddr[k]];
            end
        end

        assign rdata[k] = rdata_reg;
    end

endmodule

@@ rtl/rvx_exec.sv @@
// ----------------------------------------------------------------------------
// RV32I execute logic
// Decodes one instruction word and computes ALU, branch and address results.
// ----------------------------------------------------------------------------
module rvx_exec
    import rvx_pkg::*;
(
    input  logic [31:0] ins,
    input  logic [31:0] pc,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output exec_res_t   res
);

    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic [31:0] opb;
    logic [4:0]  shamt;
    logic        lt_s;
    logic        lt_u;
    logic        take;
    logic        alt;
    logic [31:0] alu;

    assign op    = ins[6:0];
    assign f3    = ins[14:12];
    assign f7    = ins[31:25];
    assign imm_i = {{20{ins[31]}}, ins[31:20]};
    assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    assign imm_u = {ins[31:12], 12'd0};
    assign opb   = (op == OP_REG) ? b : imm_i;
    assign shamt = opb[4:0];
    assign lt_s  = $signed(a) < $signed(opb);
    assign lt_u  = a < opb;
    assign alt   = (op == OP_REG) && (f7 == F7_ALT);

    always_comb
    begin
        unique case (f3)
            3'd0: alu = alt ? a - opb : a + opb;
            3'd1: alu = a << shamt;
            3'd2: alu = {31'd0, lt_s};
            3'd3: alu = {31'd0, lt_u};
            3'd4: alu = a ^ opb;
            3'd5: alu = (f7 == F7_ALT) ? 32'($signed(a) >>> shamt) : a >> shamt;
            3'd6: alu = a | opb;
            default: alu = a & opb;
        endcase
    end

    always_comb
    begin
        unique case (f3)
            3'd0: take = a == b;
            3'd1: take = a != b;
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = a < b;
            default: take = a >= b;
        endcase
    end

    always_comb
    begin
        res        = '0;
        res.status = STAT_OK;
        res.npc    = pc + 32'd4;
        res.rd     = ins[11:7];
        res.f3     = f3;
        res.addr   = a + imm_i;
        res.rd_we  = ins[11:7] != 5'd0;
        unique case (op)
            OP_LUI:   res.value = imm_u;
            OP_AUIPC: res.value = pc + imm_u;
            OP_JAL:
            begin
                res.value = pc + 32'd4;
                res.npc   = pc + imm_j;
            end
            OP_JALR:
            begin
                if (f3 != 3'd0) res.status = STAT_ILLEGAL;
                res.value = pc + 32'd4;
                res.npc   = (a + imm_i) & ~32'd1;
            end
            OP_BRANCH:
            begin
                res.rd_we = 1'b0;
                if (f3 == 3'd2 || f3 == 3'd3) res.status = STAT_ILLEGAL;
                else if (take) res.npc = pc + imm_b;
            end
            OP_LOAD:
            begin
                res.rd_we = 1'b0;
                res.load  = 1'b1;
                if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) res.status = STAT_ILLEGAL;
            end
            OP_STORE:
            begin
                res.rd_we = 1'b0;
                res.store = 1'b1;
                res.addr  = a + imm_s;
                if (f3 > 3'd2) res.status = STAT_ILLEGAL;
            end
            OP_IMM:
            begin
                res.value = alu;
                if (f3 == 3'd1 && f7 != 7'd0) res.status = STAT_ILLEGAL;
                if (f3 == 3'd5 && f7 != 7'd0 && f7 != F7_ALT) res.status = STAT_ILLEGAL;
            end
            OP_REG:
            begin
                res.value = alu;
                if (f7 != 7'd0 && !(f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)))
                    res.status = STAT_ILLEGAL;
            end
            OP_FENCE: res.status = STAT_FENCE;
            OP_SYSTEM:
            begin
                if (ins == INS_ECALL) res.status = STAT_ECALL;
                else if (ins == INS_EBREAK) res.status = STAT_EBREAK;
                else res.status = STAT_ILLEGAL;
            end
            default: res.status = STAT_UNKNOWN;
        endcase
        if (res.status != STAT_OK)
        begin
            res.rd_we = 1'b0;
            res.load  = 1'b0;
            res.store = 1'b0;
        end
    end

endmodule

@@ rtl/rv32i_execute_step_top.sv @@
// Most items fill the output register from S_EXEC, loads from S_MEM after S_EXEC, and
// ECALL from S_ARG3 after S_ARG1 and S_ARG2 (a7 and a0..a4 come out of the two register
// file ports over three reads). One item at a time: s_tready is high only in S_ACC, and
// the register file read then the write-back bound it. A held result does not block the
// next accept. Reset: pc, entry, stack and flags clear at once; a clearing pass then
// zeroes data memory and register file, accepting no item (MEM_BYTES a power of two).
// ----------------------------------------------------------------------------
// RV32I execute step top level
// Sequencer around register file and data memory, with an output register.
// ----------------------------------------------------------------------------
module rv32i_execute_step_top
    import rvx_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // instruction, byte_address, write_value
    input  logic [1:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [263:0] m_tdata,   // next_pc, dest_index, dest_value, call_number,
                                    // arg_first .. arg_fifth, zero pad
    output logic [2:0]   m_tuser    // status
);

    localparam int ROWS = MEM_BYTES / 4;
    localparam int RW = $clog2(ROWS);

    typedef enum logic [2:0] {
        S_CLR, S_ACC, S_EXEC, S_MEM, S_ARG1, S_ARG2, S_ARG3
    } state_t;

    state_t      state_reg;
    logic [RW-1:0] clr_reg;
    logic [31:0] entry_reg, stack_reg, pc_reg;
    logic        wait_reg;
    logic [1:0]  func_reg;
    logic [31:0] ins_reg, ba_reg, wval_reg;
    logic [31:0] a7_reg, a0_reg, a1_reg, a2_reg;
    logic [4:0]  ld_rd_reg;
    logic [1:0]  ld_off_reg;
    logic [2:0]  ld_f3_reg;

    logic        out_valid_reg;
    logic [31:0] o_pc_reg, o_val_reg, o_a7_reg, o_a0_reg, o_a1_reg, o_a2_reg,
                 o_a3_reg, o_a4_reg;
    logic [4:0]  o_rd_reg;
    logic [2:0]  o_stat_reg;

    logic        accept, out_free, ecall_path;
    logic        rf_we, rf_re;
    logic [4:0]  rf_waddr, rf_ra, rf_rb;
    logic [31:0] rf_wdata, rf_da, rf_db;
    logic [3:0]  dm_we;
    logic [3:0][RW-1:0] dm_waddr, dm_raddr;
    logic [3:0][7:0] dm_wdata, dm_rdata;
    logic        dm_re;
    exec_res_t   ex;
    logic [31:0] ld_raw, ld_val;
    logic [31:0] ld_byte_addr [4];
    logic [1:0]  lane_off [4];
    logic [2:0]  st_bytes;

    assign cfg_ready = 1'b1;
    assign s_tready  = state_reg == S_ACC;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign ecall_path = s_tuser == FUNC_EXEC && (wait_reg || s_tdata[31:0] == INS_ECALL);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = o_stat_reg;
    assign m_tdata  = {3'd0, o_a4_reg, o_a3_reg, o_a2_reg, o_a1_reg, o_a0_reg, o_a7_reg,
                       o_val_reg, o_rd_reg, o_pc_reg};

    rvx_regfile u_rf (
        .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata), .re(rf_re),
        .raddr_a(rf_ra), .raddr_b(rf_rb), .rdata_a(rf_da), .rdata_b(rf_db)
    );

    rvx_dmem #(.MEM_BYTES(MEM_BYTES)) u_dm (
        .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata), .re(dm_re),
        .raddr(dm_raddr), .rdata(dm_rdata)
    );

    rvx_exec u_ex (.ins(ins_reg), .pc(pc_reg), .a(rf_da), .b(rf_db), .res(ex));

    // store size in bytes
    always_comb
    begin
        unique case (ex.f3[1:0])
            2'd0:    st_bytes = 3'd1;
            2'd1:    st_bytes = 3'd2;
            default: st_bytes = 3'd4;
        endcase
    end

    // lane k carries byte (k - addr) mod 4 of the access
    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        assign lane_off[k]     = 2'(k) - ex.addr[1:0];
        assign ld_byte_addr[k] = ex.addr + {30'd0, lane_off[k]};
        assign dm_raddr[k]     = ld_byte_addr[k][RW+1:2];
    end

    assign dm_re = state_reg == S_EXEC && func_reg == FUNC_EXEC && ex.load && out_free;

    always_comb
    begin
        dm_we    = '0;
        dm_waddr = '0;
        dm_wdata = '0;
        if (state_reg == S_CLR)
        begin
            dm_we = 4'hF;
            for (int k = 0; k < 4; k++) dm_waddr[k] = clr_reg;
        end
        else if (state_reg == S_EXEC && out_free)
        begin
            if (func_reg == FUNC_PRELOAD)
            begin
                dm_we[ba_reg[1:0]]    = 1'b1;
                dm_waddr[ba_reg[1:0]] = ba_reg[RW+1:2];
                dm_wdata[ba_reg[1:0]] = wval_reg[7:0];
            end
            else if (func_reg == FUNC_EXEC && ex.store)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    dm_we[k]    = {1'b0, lane_off[k]} < st_bytes;
                    dm_waddr[k] = ld_byte_addr[k][RW+1:2];
                    dm_wdata[k] = 8'(rf_db >> {lane_off[k], 3'd0});
                end
            end
        end
    end

    // load data: byte i sits in lane (addr + i) mod 4
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            ld_raw[8*i +: 8] = dm_rdata[2'(ld_off_reg + 2'(i))];
        unique case (ld_f3_reg)
            3'd0:    ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
            3'd1:    ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
            3'd4:    ld_val = {24'd0, ld_raw[7:0]};
            3'd5:    ld_val = {16'd0, ld_raw[15:0]};
            default: ld_val = ld_raw;
        endcase
    end

    // register file ports
    always_comb
    begin
        rf_re = 1'b0;
        rf_ra = s_tdata[19:15];
        rf_rb = s_tdata[24:20];
        unique case (state_reg)
            S_ACC:
            begin
                rf_re = accept;
                if (ecall_path)
                begin
                    rf_ra = REG_A7;
                    rf_rb = REG_A0;
                end
            end
            S_ARG1:
            begin
                rf_re = 1'b1;
                rf_ra = REG_A1;
                rf_rb = REG_A2;
            end
            S_ARG2:
            begin
                rf_re = 1'b1;
                rf_ra = REG_A3;
                rf_rb = REG_A4;
            end
            default: ;
        endcase

        rf_we    = 1'b0;
        rf_waddr = ex.rd;
        rf_wdata = ex.value;
        unique case (state_reg)
            S_CLR:
            begin
                rf_we    = clr_reg < RW'(32);
                rf_waddr = clr_reg[4:0];
                rf_wdata = '0;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    unique case (func_reg)
                        FUNC_EXEC:   rf_we = ex.rd_we;
                        FUNC_SYSRET:
                        begin
                            rf_we    = 1'b1;
                            rf_waddr = REG_A0;
                            rf_wdata = wval_reg;
                        end
                        FUNC_START:
                        begin
                            rf_we    = 1'b1;
                            rf_waddr = REG_SP;
                            rf_wdata = stack_reg;
                        end
                        default: ;
                    endcase
                end
            end
            S_MEM:
            begin
                rf_we    = out_free && ld_rd_reg != 5'd0;
                rf_waddr = ld_rd_reg;
                rf_wdata = ld_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            entry_reg     <= '0;
            stack_reg     <= '0;
            pc_reg        <= '0;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ENTRY) entry_reg <= cfg_data;
                else stack_reg <= cfg_data;
            end
            if (m_tready) out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + RW'(1);
                    if (clr_reg == RW'(ROWS - 1)) state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (accept)
                    begin
                        func_reg  <= s_tuser;
                        ins_reg   <= s_tdata[31:0];
                        ba_reg    <= s_tdata[63:32];
                        wval_reg  <= s_tdata[95:64];
                        state_reg <= ecall_path ? S_ARG1 : S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        o_stat_reg    <= STAT_OK;
                        o_pc_reg      <= pc_reg;
                        o_rd_reg      <= '0;
                        o_val_reg     <= '0;
                        o_a7_reg <= '0; o_a0_reg <= '0; o_a1_reg <= '0;
                        o_a2_reg <= '0; o_a3_reg <= '0; o_a4_reg <= '0;
                        state_reg     <= S_ACC;
                        unique case (func_reg)
                            FUNC_EXEC:
                            begin
                                o_stat_reg <= ex.status;
                                if (ex.status == STAT_OK)
                                begin
                                    pc_reg   <= ex.npc;
                                    o_pc_reg <= ex.npc;
                                    if (ex.rd_we)
                                    begin
                                        o_rd_reg  <= ex.rd;
                                        o_val_reg <= ex.value;
                                    end
                                    if (ex.load)
                                    begin
                                        out_valid_reg <= 1'b0;
                                        ld_rd_reg     <= ex.rd;
                                        ld_off_reg    <= ex.addr[1:0];
                                        ld_f3_reg     <= ex.f3;
                                        state_reg     <= S_MEM;
                                    end
                                end
                            end
                            FUNC_SYSRET:
                            begin
                                wait_reg  <= 1'b0;
                                o_rd_reg  <= REG_A0;
                                o_val_reg <= wval_reg;
                            end
                            FUNC_START:
                            begin
                                wait_reg  <= 1'b0;
                                pc_reg    <= entry_reg;
                                o_pc_reg  <= entry_reg;
                                o_rd_reg  <= REG_SP;
                                o_val_reg <= stack_reg;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MEM:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        o_rd_reg      <= ld_rd_reg;
                        o_val_reg     <= (ld_rd_reg != 5'd0) ? ld_val : 32'd0;
                        state_reg     <= S_ACC;
                    end
                end
                S_ARG1:
                begin
                    a7_reg    <= rf_da;
                    a0_reg    <= rf_db;
                    state_reg <= S_ARG2;
                end
                S_ARG2:
                begin
                    a1_reg    <= rf_da;
                    a2_reg    <= rf_db;
                    state_reg <= S_ARG3;
                end
                S_ARG3:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        o_stat_reg    <= STAT_ECALL;
                        o_rd_reg      <= '0;
                        o_val_reg     <= '0;
                        o_a7_reg <= a7_reg; o_a0_reg <= a0_reg; o_a1_reg <= a1_reg;
                        o_a2_reg <= a2_reg; o_a3_reg <= rf_da;  o_a4_reg <= rf_db;
                        // a fresh ECALL advances the pc; a repeat while waiting does not
                        if (wait_reg)
                        begin
                            o_pc_reg <= pc_reg;
                        end
                        else
                        begin
                            o_pc_reg <= pc_reg + 32'd4;
                            pc_reg   <= pc_reg + 32'd4;
                            wait_reg <= 1'b1;
                        end
                        state_reg <= S_ACC;
                    end
                end
                default: state_reg <= S_ACC;
            endcase
        end
    end

`include "rv32i_execute_step_top_assert.svh"

    `RVX_ASSERT_NEXT(a_one_in_flight, accept, !s_tready, "second beat accepted in flight")
    `RVX_ASSERT_IMPLY(a_x0_kept, rf_we && rf_waddr == 5'd0, state_reg == S_CLR,
        "x0 written outside clearing pass")
    `RVX_ASSERT_IMPLY(a_args_ecall_only, out_valid_reg && o_stat_reg != STAT_ECALL,
        o_a7_reg == 32'd0 && o_a0_reg == 32'd0, "call arguments on non-ecall result")

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// RV32I execute step testbench
// Drives instruction, syscall, start and preload beats. A scoreboard class
// keeps its own pc, register file and data memory, predicts every result
// beat and checks it field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb
    import rvx_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] npc;
        logic [2:0]  status;
        logic [4:0]  dest;
        logic [31:0] value;
        logic [31:0] a7_val;
        logic [31:0] arg0;
        logic [31:0] arg1;
        logic [31:0] arg2;
        logic [31:0] arg3;
        logic [31:0] arg4;
    } step_res_t;

    class core_scoreboard;
        logic [31:0] entry_pc;
        logic [31:0] stack_val;
        logic [31:0] pc;
        logic [31:0] regs [32];
        logic [7:0]  mem [MEM_BYTES_DEF];
        bit          waiting;
        step_res_t   expected_q [$];
        int          errors;
        int          checked;

        function new();
            entry_pc  = '0;
            stack_val = '0;
            pc        = '0;
            waiting   = 0;
            errors    = 0;
            checked   = 0;
            foreach (regs[i]) regs[i] = '0;
            foreach (mem[i]) mem[i] = '0;
        endfunction

        function logic [31:0] load_bytes(logic [31:0] addr, int n);
            logic [31:0] v;
            v = '0;
            for (int i = 0; i < n; i++)
                v[8*i +: 8] = mem[(addr + i) % MEM_BYTES_DEF];
            return v;
        endfunction

        // Returns status; store side effects happen only on legal stores.
        function logic [2:0] exec_word(logic [31:0] ins, output logic [31:0] npc,
                                       output logic [4:0] wi, output logic [31:0] wv);
            logic [6:0]  op;
            logic [4:0]  rd;
            logic [2:0]  f3;
            logic [6:0]  f7;
            logic [31:0] a, b, ii, v, addr, boff;
            bit          wr, take;
            op = ins[6:0];
            rd = ins[11:7];
            f3 = ins[14:12];
            f7 = ins[31:25];
            a  = regs[ins[19:15]];
            b  = regs[ins[24:20]];
            ii = {{20{ins[31]}}, ins[31:20]};
            v  = '0;
            wr = 1;
            take = 0;
            wi = '0;
            wv = '0;
            npc = pc + 4;
            case (op)
                OP_LUI:   v = {ins[31:12], 12'b0};
                OP_AUIPC: v = pc + {ins[31:12], 12'b0};
                OP_JAL:
                begin
                    v = pc + 4;
                    npc = pc + {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
                end
                OP_JALR:
                begin
                    if (f3 != 3'd0) return STAT_ILLEGAL;
                    v = pc + 4;
                    npc = (a + ii) & ~32'd1;
                end
                OP_BRANCH:
                begin
                    wr = 0;
                    case (f3)
                        3'd0: take = (a == b);
                        3'd1: take = (a != b);
                        3'd4: take = ($signed(a) < $signed(b));
                        3'd5: take = !($signed(a) < $signed(b));
                        3'd6: take = (a < b);
                        3'd7: take = (a >= b);
                        default: return STAT_ILLEGAL;
                    endcase
                    boff = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
                    if (take) npc = pc + boff;
                end
                OP_LOAD:
                begin
                    addr = a + ii;
                    case (f3)
                        3'd0: begin v = load_bytes(addr, 1); v = {{24{v[7]}}, v[7:0]}; end
                        3'd1: begin v = load_bytes(addr, 2); v = {{16{v[15]}}, v[15:0]}; end
                        3'd2: v = load_bytes(addr, 4);
                        3'd4: v = load_bytes(addr, 1);
                        3'd5: v = load_bytes(addr, 2);
                        default: return STAT_ILLEGAL;
                    endcase
                end
                OP_STORE:
                begin
                    if (f3 > 3'd2) return STAT_ILLEGAL;
                    wr = 0;
                    addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
                    for (int i = 0; i < (1 << f3); i++)
                        mem[(addr + i) % MEM_BYTES_DEF] = b[8*i +: 8];
                end
                OP_IMM:
                begin
                    case (f3)
                        3'd0: v = a + ii;
                        3'd1:
                        begin
                            if (f7 != 7'd0) return STAT_ILLEGAL;
                            v = a << ii[4:0];
                        end
                        3'd2: v = ($signed(a) < $signed(ii)) ? 32'd1 : 32'd0;
                        3'd3: v = (a < ii) ? 32'd1 : 32'd0;
                        3'd4: v = a ^ ii;
                        3'd5:
                        begin
                            if (f7 == 7'd0) v = a >> ii[4:0];
                            else if (f7 == F7_ALT) v = $signed(a) >>> ii[4:0];
                            else return STAT_ILLEGAL;
                        end
                        3'd6: v = a | ii;
                        default: v = a & ii;
                    endcase
                end
                OP_REG:
                begin
                    if (f7 != 7'd0 && !(f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)))
                        return STAT_ILLEGAL;
                    case (f3)
                        3'd0: v = (f7 != 7'd0) ? a - b : a + b;
                        3'd1: v = a << b[4:0];
                        3'd2: v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                        3'd3: v = (a < b) ? 32'd1 : 32'd0;
                        3'd4: v = a ^ b;
                        3'd5: v = (f7 != 7'd0) ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
                        3'd6: v = a | b;
                        default: v = a & b;
                    endcase
                end
                OP_FENCE: return STAT_FENCE;
                OP_SYSTEM:
                begin
                    if (ins == INS_ECALL)
                    begin
                        waiting = 1;
                        return STAT_ECALL;
                    end
                    if (ins == INS_EBREAK) return STAT_EBREAK;
                    return STAT_ILLEGAL;
                end
                default: return STAT_UNKNOWN;
            endcase
            if (wr && rd != 5'd0)
            begin
                wi = rd;
                wv = v;
            end
            return STAT_OK;
        endfunction

        function void note_input(logic [1:0] func, logic [31:0] ins,
                                 logic [31:0] baddr, logic [31:0] wval);
            step_res_t   r;
            logic [31:0] npc, wv;
            logic [4:0]  wi;
            logic [2:0]  st;
            r = '0;
            npc = pc;
            wi = '0;
            wv = '0;
            st = STAT_OK;
            case (func)
                FUNC_EXEC:
                begin
                    if (waiting) st = STAT_ECALL;
                    else
                    begin
                        st = exec_word(ins, npc, wi, wv);
                        if (st == STAT_OK || st == STAT_ECALL)
                        begin
                            pc = npc;
                            if (wi != 5'd0) regs[wi] = wv;
                        end
                        else
                        begin
                            npc = pc;
                            wi = '0;
                            wv = '0;
                        end
                    end
                end
                FUNC_SYSRET:
                begin
                    regs[REG_A0] = wval;
                    waiting = 0;
                    wi = REG_A0;
                    wv = wval;
                end
                FUNC_START:
                begin
                    pc = entry_pc;
                    regs[REG_SP] = stack_val;
                    waiting = 0;
                    npc = pc;
                    wi = REG_SP;
                    wv = stack_val;
                end
                default: mem[baddr % MEM_BYTES_DEF] = wval[7:0];
            endcase
            r.npc = npc;
            r.status = st;
            r.dest = wi;
            r.value = wv;
            if (st == STAT_ECALL)
            begin
                r.a7_val = regs[REG_A7];
                r.arg0 = regs[REG_A0];
                r.arg1 = regs[REG_A1];
                r.arg2 = regs[REG_A2];
                r.arg3 = regs[REG_A3];
                r.arg4 = regs[REG_A4];
            end
            expected_q.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] exp);
            $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, exp);
            errors++;
        endtask

        task check_result(step_res_t got);
            step_res_t e;
            if (expected_q.size() == 0)
            begin
                report("unexpected beat", got.npc, '0);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.npc != e.npc) report("next_pc", got.npc, e.npc);
            if (got.status != e.status) report("status", 32'(got.status), 32'(e.status));
            if (got.dest != e.dest) report("dest_index", 32'(got.dest), 32'(e.dest));
            if (got.value != e.value) report("dest_value", got.value, e.value);
            if (got.a7_val != e.a7_val) report("call_number", got.a7_val, e.a7_val);
            if (got.arg0 != e.arg0) report("arg_first", got.arg0, e.arg0);
            if (got.arg1 != e.arg1) report("arg_second", got.arg1, e.arg1);
            if (got.arg2 != e.arg2) report("arg_third", got.arg2, e.arg2);
            if (got.arg3 != e.arg3) report("arg_fourth", got.arg3, e.arg3);
            if (got.arg4 != e.arg4) report("arg_fifth", got.arg4, e.arg4);
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;   // instruction, byte_address, write_value
    logic [1:0]   s_tuser;   // func
    logic         m_tvalid;
    logic         m_tready;
    logic [263:0] m_tdata;   // next_pc, dest_index, dest_value, call_number, arg_first..fifth
    logic [2:0]   m_tuser;   // status

    core_scoreboard sb;
    int func_count [4];
    int ecall_count;
    bit rx_burst;

    rv32i_execute_step_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    task send_beat(logic [1:0] func, logic [31:0] ins, logic [31:0] baddr,
                   logic [31:0] wval);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {wval, baddr, ins};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(func, ins, baddr, wval);
        func_count[func]++;
        if (func == FUNC_EXEC && ins == INS_ECALL) ecall_count++;
    endtask

    // Config only while idle: drain results, then let the pipeline settle.
    task drain_pipe();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task write_cfg(logic idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_ENTRY) sb.entry_pc = val;
        else sb.stack_val = val;
    endtask

    function logic [31:0] rand_word();
        logic [31:0] r;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [6:0]  ops [11];
        r   = $urandom;
        rd  = 5'($urandom);
        rs1 = 5'($urandom);
        rs2 = 5'($urandom);
        f3  = 3'($urandom);
        f7  = ($urandom_range(0, 1) == 1) ? F7_ALT : 7'd0;
        ops = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH, OP_LOAD,
                OP_STORE, OP_IMM, OP_REG, OP_FENCE, OP_SYSTEM};
        case ($urandom_range(0, 15))
            0:  return {r[31:12], rd, OP_LUI};
            1:  return {r[31:12], rd, OP_AUIPC};
            2:  return {r[31:12], rd, OP_JAL};
            3:  return {r[31:20], rs1, 3'd0, rd, OP_JALR};
            4:
            begin
                while (f3 == 3'd2 || f3 == 3'd3) f3 = 3'($urandom);
                return {r[31:25], rs2, rs1, f3, r[11:7], OP_BRANCH};
            end
            5:
            begin
                while (f3 == 3'd3 || f3 >= 3'd6) f3 = 3'($urandom);
                return {r[31:20], rs1, f3, rd, OP_LOAD};
            end
            6:  return {r[31:25], rs2, rs1, 3'($urandom_range(0, 2)), r[11:7], OP_STORE};
            7, 8:
            begin
                if (f3 == 3'd1) return {7'd0, r[24:20], rs1, f3, rd, OP_IMM};
                if (f3 == 3'd5) return {f7, r[24:20], rs1, f3, rd, OP_IMM};
                return {r[31:20], rs1, f3, rd, OP_IMM};
            end
            9, 10:
            begin
                if (f3 != 3'd0 && f3 != 3'd5) f7 = 7'd0;
                return {f7, rs2, rs1, f3, rd, OP_REG};
            end
            11: return ($urandom_range(0, 2) == 0) ? INS_ECALL
                                                   : {r[31:20], 5'd0, 3'd0, rd, OP_IMM};
            12: return r;
            13: return {r[31:7], ops[$urandom_range(0, 10)]};
            14: return ($urandom_range(0, 1) == 1) ? INS_EBREAK : {r[31:7], OP_FENCE};
            default: return {r[31:20], 5'd0, 3'd0, rd, OP_IMM};
        endcase
    endfunction

    task rand_item();
        int r;
        r = $urandom_range(0, 99);
        if (sb.waiting && r < 80) send_beat(FUNC_SYSRET, $urandom, $urandom, $urandom);
        else if (r < 88) send_beat(FUNC_EXEC, rand_word(), $urandom, $urandom);
        else if (r < 94) send_beat(FUNC_PRELOAD, $urandom, $urandom, $urandom);
        else if (r < 97) send_beat(FUNC_SYSRET, $urandom, $urandom, $urandom);
        else send_beat(FUNC_START, $urandom, $urandom, $urandom);
    endtask

    // receive side
    initial
    begin
        int gap;
        step_res_t got;
        m_tready = 1'b0;
        rx_burst = 0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            got.npc      = m_tdata[31:0];
            got.dest     = m_tdata[36:32];
            got.value    = m_tdata[68:37];
            got.a7_val   = m_tdata[100:69];
            got.arg0     = m_tdata[132:101];
            got.arg1     = m_tdata[164:133];
            got.arg2     = m_tdata[196:165];
            got.arg3     = m_tdata[228:197];
            got.arg4     = m_tdata[260:229];
            got.status   = m_tuser;
            sb.check_result(got);
        end
    end

    initial
    begin
        logic [31:0] entries [4];
        logic [31:0] stacks [4];
        sb = new();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ENTRY;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_EXEC;
        ecall_count = 0;
        foreach (func_count[i]) func_count[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_cfg(CFG_ENTRY, 32'h0000_0100);
        write_cfg(CFG_STACK, 32'h0000_2000);
        send_beat(FUNC_START, '0, '0, '0);
        send_beat(FUNC_EXEC, {20'hFFFFF, 5'd5, OP_LUI}, '0, '0);
        send_beat(FUNC_EXEC, {12'hFFF, 5'd0, 3'd0, 5'd6, OP_IMM}, '0, '0);
        // signed vs unsigned compare of -1 against 1
        send_beat(FUNC_EXEC, {12'd1, 5'd6, 3'd2, 5'd7, OP_IMM}, '0, '0);
        send_beat(FUNC_EXEC, {12'd1, 5'd6, 3'd3, 5'd8, OP_IMM}, '0, '0);
        send_beat(FUNC_EXEC, {12'd5, 5'd6, 3'd0, 5'd0, OP_IMM}, '0, '0);
        // misaligned word store wrapping past the end of memory
        send_beat(FUNC_EXEC, {7'h7F, 5'd6, 5'd0, 3'd2, 5'h1E, OP_STORE}, '0, '0);
        send_beat(FUNC_PRELOAD, 32'hFFFF_FFFF, 32'hFFFF_0080, 32'hFFFF_FF80);
        send_beat(FUNC_EXEC, {12'h080, 5'd0, 3'd0, 5'd9, OP_LOAD}, '0, '0);
        send_beat(FUNC_EXEC, {12'hFFE, 5'd0, 3'd1, 5'd11, OP_LOAD}, '0, '0);
        send_beat(FUNC_EXEC, {12'hFFE, 5'd0, 3'd4, 5'd12, OP_LOAD}, '0, '0);
        send_beat(FUNC_EXEC, {12'hFFE, 5'd0, 3'd5, 5'd15, OP_LOAD}, '0, '0);
        send_beat(FUNC_EXEC, {12'hFFE, 5'd0, 3'd2, 5'd16, OP_LOAD}, '0, '0);
        send_beat(FUNC_EXEC, {12'd3, 5'd6, 3'd0, 5'd1, OP_JALR}, '0, '0);
        send_beat(FUNC_EXEC, {7'd0, 5'd0, 5'd0, 3'd0, 5'b01000, OP_BRANCH}, '0, '0);
        send_beat(FUNC_EXEC, {7'h7F, 5'd0, 5'd6, 3'd4, 5'b11101, OP_BRANCH}, '0, '0);
        send_beat(FUNC_EXEC, {F7_ALT, 5'd4, 5'd6, 3'd5, 5'd13, OP_IMM}, '0, '0);
        send_beat(FUNC_EXEC, {F7_ALT, 5'd6, 5'd0, 3'd0, 5'd14, OP_REG}, '0, '0);
        send_beat(FUNC_EXEC, INS_ECALL, '0, '0);
        send_beat(FUNC_EXEC, {12'd1, 5'd0, 3'd0, 5'd20, OP_IMM}, '0, '0);
        send_beat(FUNC_SYSRET, '0, '0, 32'hFFFF_FFFF);
        send_beat(FUNC_SYSRET, '0, '0, 32'h0000_0000);
        send_beat(FUNC_EXEC, {25'd0, OP_FENCE}, '0, '0);
        send_beat(FUNC_EXEC, INS_EBREAK, '0, '0);
        send_beat(FUNC_EXEC, {25'd0, 7'h7F}, '0, '0);
        send_beat(FUNC_EXEC, 32'h0020_0073, '0, '0);
        send_beat(FUNC_EXEC, {7'd0, 5'd0, 5'd0, 3'd2, 5'd0, OP_BRANCH}, '0, '0);
        send_beat(FUNC_EXEC, {7'd0, 5'd6, 5'd0, 3'd3, 5'd0, OP_STORE}, '0, '0);
        send_beat(FUNC_EXEC, {1'b1, 10'h3FE, 1'b1, 8'hFF, 5'd1, OP_JAL}, '0, '0);

        entries = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
        stacks  = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom};
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_pipe();
            write_cfg(CFG_ENTRY, entries[ph]);
            write_cfg(CFG_STACK, stacks[ph]);
            send_beat(FUNC_START, $urandom, $urandom, $urandom);
            for (int n = 0; n < 412; n++)
            begin
                // hold off once per phase until the block has fully drained
                if (n == 200)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (sb.expected_q.size() != 0) @(posedge clk);
                end
                rand_item();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("covered %0d exec, %0d sysret, %0d start, %0d preload beats, %0d ecalls",
                 func_count[FUNC_EXEC], func_count[FUNC_SYSRET], func_count[FUNC_START],
                 func_count[FUNC_PRELOAD], ecall_count);
        $display("%0d results checked over four config settings, %0d mismatches",
                 sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
